FILE: rtl/fbpa_pkg.sv
// Shared types and codes for the fixed block pool allocator.
`default_nettype none

package fbpa_pkg;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_CHECK   = 2'd2,
        OP_RELEASE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_BLK  = 2'd1,
        ST_REFUSED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        REG_BLOCK_BYTES    = 2'd0,
        REG_INITIAL_BLOCKS = 2'd1,
        REG_GROW_BLOCKS    = 2'd2
    } t_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_CARVE,
        S_POP,
        S_POP_WAIT,
        S_MUL,
        S_DONE
    } t_state;

    localparam int unsigned ALIGN_BYTES = 4;
    localparam int unsigned SIZE_W      = 17;   // rounded block size, up to 65536
    localparam int unsigned BYTES_W     = 24;

endpackage

`default_nettype wire

FILE: rtl/fixed_block_pool_allocator_top.sv
// Fixed-size block pool allocator: LIFO free list of block indices with link memory.
//
// A command is a transfer at a clock edge where start is high and busy is low.
// Exactly one result follows per command, shown for one cycle with o_done high;
// the receiver cannot stall it. A carve runs before the result when one happens
// (initial carve on the first command after reset, growth when alloc finds the
// list empty). The next command can be transferred in the cycle after o_done.
// The carve sequencer pushes one block per cycle through the single write port
// of the link memory. Alloc adds a state that tests the head and launches the
// registered link read, and one that takes the new head from that read. The
// outstanding byte count goes through one registered multiplier in its own
// state. busy is high from the transfer until the cycle after o_done's cycle
// begins. Configuration writes are always accepted (o_cfg_ready is high) and
// must only happen while the block is idle.
`default_nettype none

module fixed_block_pool_allocator_top
    import fbpa_pkg::*;
#(
    parameter int unsigned POOL_BLOCKS = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // command channel
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_op,
    input  wire logic [7:0]  i_block_index,
    // result channel
    output logic             o_done,
    output logic [1:0]       o_status,
    output logic [7:0]       o_granted_index,
    output logic [23:0]      o_outstanding_bytes,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    localparam int unsigned IW   = (POOL_BLOCKS > 1) ? $clog2(POOL_BLOCKS) : 1;
    localparam int unsigned HW   = IW + 1;                      // head, POOL_BLOCKS = empty
    localparam int unsigned CW   = $clog2(POOL_BLOCKS + 1);     // carved count
    localparam int unsigned FW   = $clog2(2 * POOL_BLOCKS);     // free count
    localparam int unsigned XW   = (IW > 8) ? IW : 8;
    localparam int unsigned SW   = ((CW > 9) ? CW : 9) + 1;     // capacity compare
    localparam int unsigned PW   = FW + SIZE_W;                 // product
    localparam logic [HW-1:0] HEAD_EMPTY = HW'(POOL_BLOCKS);
    localparam logic [FW-1:0] FREE_MAX   = FW'(2 * POOL_BLOCKS - 1);

    // configuration
    logic [15:0] r_block_bytes;
    logic [8:0]  r_initial_blocks;
    logic [8:0]  r_grow_blocks;

    // pool state
    logic [HW-1:0] r_head,    n_head;
    logic [CW-1:0] r_carved,  n_carved;
    logic [FW-1:0] r_free,    n_free;
    logic          r_started, n_started;

    // sequencer
    t_state        r_state,   n_state;
    t_state        r_ret,     n_ret;
    logic [8:0]    r_cnt,     n_cnt;
    t_op           r_op,      n_op;
    logic [7:0]    r_idx,     n_idx;
    t_status       r_status,  n_status;
    logic [7:0]    r_granted, n_granted;
    logic [PW-1:0] r_prod,    n_prod;

    // link memory
    logic [HW-1:0] r_link [POOL_BLOCKS];
    logic [HW-1:0] r_rd;
    logic          n_we;
    logic [IW-1:0] n_waddr;
    logic [HW-1:0] n_wdata;

    logic [XW-1:0]     idx_x;
    logic [XW-1:0]     head_x;
    logic              idx_ok;
    logic              head_empty;
    logic              init_fits;
    logic              grow_fits;
    logic [SIZE_W-1:0] size_rnd;
    logic [FW-1:0]     carved_x;
    logic [FW-1:0]     diff;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_bytes    <= 16'd4;
            r_initial_blocks <= '0;
            r_grow_blocks    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_BLOCK_BYTES:    r_block_bytes    <= i_cfg_data;
                REG_INITIAL_BLOCKS: r_initial_blocks <= i_cfg_data[8:0];
                REG_GROW_BLOCKS:    r_grow_blocks    <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // derived values
    assign idx_x      = XW'(r_idx);
    assign head_x     = XW'(r_head);
    assign idx_ok     = ({24'd0, r_idx} < 32'(POOL_BLOCKS));
    assign head_empty = (r_head == HEAD_EMPTY);
    assign init_fits  = (SW'(r_carved) + SW'(r_initial_blocks)) <= SW'(POOL_BLOCKS);
    assign grow_fits  = (SW'(r_carved) + SW'(r_grow_blocks)) <= SW'(POOL_BLOCKS);
    assign carved_x   = FW'(r_carved);
    assign diff       = (carved_x > r_free) ? (carved_x - r_free) : '0;

    // zero size is taken as one, then rounded up to a multiple of four
    always_comb begin
        if (r_block_bytes == 16'd0) begin
            size_rnd = SIZE_W'(ALIGN_BYTES);
        end else begin
            size_rnd = (SIZE_W'(r_block_bytes) + SIZE_W'(ALIGN_BYTES - 1))
                       & ~SIZE_W'(ALIGN_BYTES - 1);
        end
    end

    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_cnt     = r_cnt;
        n_op      = r_op;
        n_idx     = r_idx;
        n_status  = r_status;
        n_granted = r_granted;
        n_prod    = r_prod;
        n_head    = r_head;
        n_carved  = r_carved;
        n_free    = r_free;
        n_started = r_started;
        n_we      = 1'b0;
        n_waddr   = r_carved[IW-1:0];
        n_wdata   = r_head;
        busy      = (r_state != S_IDLE);
        o_done    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op      = t_op'(i_op);
                    n_idx     = i_block_index;
                    n_status  = ST_OK;
                    n_granted = '0;
                    n_state   = S_DISPATCH;
                    if (!r_started) begin
                        n_started = 1'b1;
                        if (r_initial_blocks != 9'd0 && init_fits) begin
                            n_cnt   = r_initial_blocks;
                            n_ret   = S_DISPATCH;
                            n_state = S_CARVE;
                        end
                    end
                end
            end
            S_DISPATCH: begin
                n_state = S_MUL;
                unique case (r_op)
                    OP_ALLOC: begin
                        n_state = S_POP;
                        if (head_empty && r_grow_blocks != 9'd0 && grow_fits) begin
                            n_cnt   = r_grow_blocks;
                            n_ret   = S_POP;
                            n_state = S_CARVE;
                        end
                    end
                    OP_FREE: begin
                        if (idx_ok) begin
                            n_we    = 1'b1;
                            n_waddr = idx_x[IW-1:0];
                            n_wdata = r_head;
                            n_head  = HW'(idx_x[IW-1:0]);
                            if (r_free != FREE_MAX) n_free = r_free + 1'b1;
                        end
                    end
                    OP_CHECK: ;
                    OP_RELEASE: begin
                        if (r_free != carved_x) begin
                            n_status = ST_REFUSED;
                        end else begin
                            n_head   = HEAD_EMPTY;
                            n_carved = '0;
                            n_free   = '0;
                        end
                    end
                    default: ;
                endcase
            end
            S_CARVE: begin
                // one block per cycle, ascending index
                n_we     = 1'b1;
                n_waddr  = r_carved[IW-1:0];
                n_wdata  = r_head;
                n_head   = HW'(r_carved[IW-1:0]);
                n_carved = r_carved + 1'b1;
                if (r_free != FREE_MAX) n_free = r_free + 1'b1;
                n_cnt    = r_cnt - 9'd1;
                if (r_cnt == 9'd1) n_state = r_ret;
            end
            S_POP: begin
                if (head_empty) begin
                    n_status = ST_NO_BLK;
                    n_state  = S_MUL;
                end else begin
                    n_granted = head_x[7:0];
                    n_state   = S_POP_WAIT;
                end
            end
            S_POP_WAIT: begin
                n_head = r_rd;
                if (r_free != '0) n_free = r_free - 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_prod  = PW'(diff) * PW'(size_rnd);
                n_state = S_DONE;
            end
            S_DONE: begin
                o_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ret     <= S_DISPATCH;
            r_cnt     <= '0;
            r_head    <= HEAD_EMPTY;
            r_carved  <= '0;
            r_free    <= '0;
            r_started <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ret     <= n_ret;
            r_cnt     <= n_cnt;
            r_head    <= n_head;
            r_carved  <= n_carved;
            r_free    <= n_free;
            r_started <= n_started;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_idx     <= n_idx;
        r_status  <= n_status;
        r_granted <= n_granted;
        r_prod    <= n_prod;
    end

    // link memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (n_we) r_link[n_waddr] <= n_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_POP) r_rd <= r_link[r_head[IW-1:0]];
    end

    assign o_status            = r_status;
    assign o_granted_index     = r_granted;
    assign o_outstanding_bytes = (r_prod > PW'(24'hFFFFFF)) ? 24'hFFFFFF
                                                            : r_prod[BYTES_W-1:0];

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for the fixed block pool allocator: directed and random command streams.
module tb;
    import fbpa_pkg::*;

    localparam int unsigned POOL_BLOCKS = 256;
    localparam int unsigned FREE_LIMIT  = 2 * POOL_BLOCKS - 1;
    localparam logic [1:0]  REG_UNUSED  = 2'd3;       // index with no register behind it
    localparam logic [23:0] BYTES_SAT   = 24'hFFFFFF;
    localparam int unsigned NO_LINK     = POOL_BLOCKS; // list head value for empty

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  granted;
        logic [23:0] bytes;
    } pool_result_t;

    // DUT signals
    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic [1:0]  i_op;
    logic [7:0]  i_block_index;
    logic        i_cfg_valid;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    wire         busy;
    wire         o_done;
    wire [1:0]   o_status;
    wire [7:0]   o_granted_index;
    wire [23:0]  o_outstanding_bytes;
    wire         o_cfg_ready;

    fixed_block_pool_allocator_top #(
        .POOL_BLOCKS(POOL_BLOCKS)
    ) uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_op                (i_op),
        .i_block_index       (i_block_index),
        .o_done              (o_done),
        .o_status            (o_status),
        .o_granted_index     (o_granted_index),
        .o_outstanding_bytes (o_outstanding_bytes),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    // Allocator shadow: configuration, link memory, list head and counters.
    int unsigned  cfg_block_bytes;
    int unsigned  cfg_initial;
    int unsigned  cfg_grow;
    int unsigned  link_mem [POOL_BLOCKS];
    int unsigned  list_head;
    int unsigned  carved_cnt;
    int unsigned  free_cnt;
    bit           pool_started;

    pool_result_t expected_q [$];   // one entry per accepted command, oldest first
    logic [7:0]   held_q [$];       // indices granted and not yet returned (stimulus only)
    pool_result_t exp_head;

    bit no_idle;
    int n_sent, n_results, n_cfg, n_carves, mismatches;
    int n_no_blk, n_refused, n_sat;
    int op_count [4];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit, far above the slowest legal run.
    initial begin
        #3000000;
        $display("[fixed_block_pool_allocator_top] ERROR");
        $display("timeout with %0d results outstanding", expected_q.size());
        $finish;
    end

    // ------------------------------------------------------------------
    // Shadow allocator
    // ------------------------------------------------------------------
    function automatic void pool_push(input int unsigned idx);
        link_mem[idx] = list_head;
        list_head     = idx;
        if (free_cnt < FREE_LIMIT) free_cnt++;
    endfunction

    // A carve that would overflow the pool carves nothing.
    function automatic void pool_carve(input int unsigned n);
        int unsigned k;
        if (carved_cnt + n > POOL_BLOCKS) return;
        for (k = 0; k < n; k++) pool_push(carved_cnt + k);
        carved_cnt += n;
        n_carves++;
    endfunction

    function automatic logic [23:0] pool_bytes();
        int unsigned     sz;
        longint unsigned prod;
        sz = (cfg_block_bytes == 0) ? 1 : cfg_block_bytes;
        sz = (sz + ALIGN_BYTES - 1) & ~(ALIGN_BYTES - 1);
        if (free_cnt >= carved_cnt) return '0;  // more frees than carves reads as zero
        prod = 64'(carved_cnt - free_cnt);
        prod = prod * 64'(sz);
        return (prod > BYTES_SAT) ? BYTES_SAT : prod[23:0];
    endfunction

    function automatic pool_result_t pool_predict(input t_op op, input logic [7:0] idx);
        pool_result_t r;
        r.status  = ST_OK;
        r.granted = '0;
        if (!pool_started) begin
            pool_started = 1'b1;
            if (cfg_initial > 0) pool_carve(cfg_initial);
        end
        case (op)
            OP_ALLOC: begin
                if (list_head >= NO_LINK && cfg_grow > 0) pool_carve(cfg_grow);
                if (list_head < NO_LINK) begin
                    r.granted = list_head[7:0];
                    list_head = link_mem[list_head];
                    if (free_cnt > 0) free_cnt--;
                end else begin
                    r.status = ST_NO_BLK;
                end
            end
            // 8-bit index is always inside a 256-block pool; pushed unchecked
            OP_FREE: pool_push(32'(idx));
            OP_CHECK: ;
            OP_RELEASE: begin
                if (free_cnt != carved_cnt) begin
                    r.status = ST_REFUSED;
                end else begin
                    list_head  = NO_LINK;
                    carved_cnt = 0;
                    free_cnt   = 0;
                end
            end
            default: ;
        endcase
        r.bytes = pool_bytes();
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // One command transfer; prediction is made at the accepting edge.
    task automatic send_cmd(input t_op op, input logic [7:0] idx);
        int           gap;
        pool_result_t r;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start         <= 1'b1;
        i_op          <= op;
        i_block_index <= idx;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        r = pool_predict(op, idx);
        expected_q.push_back(r);
        n_sent++;
        op_count[op]++;
        if (op == OP_ALLOC && r.status == ST_OK) held_q.push_back(r.granted);
        if (op == OP_RELEASE && r.status == ST_OK) held_q.delete();
        @(negedge i_clk);
    endtask

    // Register write; only called while the block is idle.
    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_BLOCK_BYTES:    cfg_block_bytes = 32'(data);
            REG_INITIAL_BLOCKS: cfg_initial     = 32'(data[8:0]);
            REG_GROW_BLOCKS:    cfg_grow        = 32'(data[8:0]);
            default: ;
        endcase
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Hold off until every result is in and the block has gone idle.
    task automatic drain();
        start <= 1'b0;
        while (expected_q.size() != 0 || busy) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Return a block we hold, or any index when nothing is held.
    task automatic free_held();
        int k;
        logic [7:0] idx;
        if (held_q.size() > 0) begin
            k   = $urandom_range(0, held_q.size() - 1);
            idx = held_q[k];
            held_q.delete(k);
        end else begin
            idx = 8'($urandom_range(0, 255));
        end
        send_cmd(OP_FREE, idx);
    endtask

    // Bring free and carved counts level, then release the pool.
    task automatic balance_and_release();
        while (free_cnt != carved_cnt) begin
            if (free_cnt > carved_cnt) send_cmd(OP_ALLOC, 8'($urandom_range(0, 255)));
            else free_held();
        end
        send_cmd(OP_RELEASE, 8'($urandom_range(0, 255)));
    endtask

    // Random stream: alloc share given, rest mostly well-formed returns.
    task automatic run_random(input int count, input int alloc_pct);
        int target;
        int r;
        target = n_sent + count;
        while (n_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < alloc_pct) begin
                send_cmd(OP_ALLOC, 8'($urandom_range(0, 255)));
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55)      free_held();
                else if (r < 63) send_cmd(OP_FREE, 8'($urandom_range(0, 255)));
                else if (r < 82) send_cmd(OP_CHECK, 8'($urandom_range(0, 255)));
                else if (r < 95) send_cmd(OP_RELEASE, 8'($urandom_range(0, 255)));
                else             balance_and_release();
            end
            if ($urandom_range(0, 99) == 0) drain();
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Initial carve of four blocks, no growth: drain the pool and refill it.
    task automatic test_initial_carve();
        cfg_write(REG_BLOCK_BYTES, 16'd5);
        cfg_write(REG_INITIAL_BLOCKS, 16'd4);
        cfg_write(REG_GROW_BLOCKS, 16'd0);
        cfg_write(REG_UNUSED, 16'hFFFF);
        send_cmd(OP_CHECK, 8'hFF);              // first command triggers the carve
        repeat (5) send_cmd(OP_ALLOC, 8'h00);   // last one finds the list empty
        send_cmd(OP_CHECK, 8'h00);
        send_cmd(OP_RELEASE, 8'hFF);            // refused, blocks outstanding
        repeat (4) free_held();
        send_cmd(OP_RELEASE, 8'h00);
        send_cmd(OP_ALLOC, 8'hFF);              // empty pool, growth disabled
    endtask

    // Growth by two, unchecked and duplicate frees, free count above carved.
    task automatic test_growth_edges();
        drain();
        cfg_write(REG_BLOCK_BYTES, 16'd0);
        cfg_write(REG_GROW_BLOCKS, 16'd2);
        repeat (3) send_cmd(OP_ALLOC, 8'hAA);
        send_cmd(OP_FREE, 8'hFF);
        send_cmd(OP_FREE, 8'h03);
        repeat (2) send_cmd(OP_ALLOC, 8'h55);
        send_cmd(OP_FREE, 8'h00);
        send_cmd(OP_FREE, 8'h00);
        send_cmd(OP_FREE, 8'h5A);
        send_cmd(OP_FREE, 8'hA5);
        send_cmd(OP_CHECK, 8'h00);
        send_cmd(OP_RELEASE, 8'h00);
        balance_and_release();
    endtask

    // Fill all 256 blocks at the largest exact size, then push the product past 24 bits.
    task automatic test_full_pool();
        drain();
        cfg_write(REG_BLOCK_BYTES, 16'd65532);
        cfg_write(REG_GROW_BLOCKS, 16'd256);
        balance_and_release();
        run_random(260, 85);
        drain();
        cfg_write(REG_BLOCK_BYTES, 16'hFFFF);
        run_random(150, 90);
    endtask

    // Growth that can never fit, then growth that fits once only.
    task automatic test_capacity();
        drain();
        cfg_write(REG_GROW_BLOCKS, 16'hFF2C);   // upper bits dropped, 300 blocks
        cfg_write(REG_BLOCK_BYTES, 16'd1);
        balance_and_release();
        repeat (3) send_cmd(OP_ALLOC, 8'($urandom_range(0, 255)));
        drain();
        cfg_write(REG_GROW_BLOCKS, 16'h01FF);
        repeat (2) send_cmd(OP_ALLOC, 8'($urandom_range(0, 255)));
        drain();
        cfg_write(REG_GROW_BLOCKS, 16'd200);
        run_random(300, 70);
    endtask

    // One block per growth, back-to-back commands.
    task automatic test_single_grow();
        drain();
        cfg_write(REG_BLOCK_BYTES, 16'd3);
        cfg_write(REG_GROW_BLOCKS, 16'd1);
        no_idle = 1'b1;
        balance_and_release();
        run_random(250, 45);
        no_idle = 1'b0;
    endtask

    // Random settings; initial_blocks writes must have no effect after the first command.
    task automatic test_random_config();
        repeat (4) begin
            drain();
            cfg_write(REG_BLOCK_BYTES, 16'($urandom_range(0, 65535)));
            cfg_write(REG_INITIAL_BLOCKS, 16'($urandom_range(0, 65535)));
            cfg_write(REG_GROW_BLOCKS, 16'($urandom_range(0, 16)));
            run_random(50, 50);
        end
    endtask

    // Flood of frees drives the free count into saturation.
    task automatic test_free_saturation();
        drain();
        cfg_write(REG_GROW_BLOCKS, 16'd256);
        cfg_write(REG_BLOCK_BYTES, 16'd4096);
        balance_and_release();
        send_cmd(OP_ALLOC, 8'h00);
        repeat (310) begin
            if ($urandom_range(0, 9) == 0) send_cmd(OP_CHECK, 8'($urandom_range(0, 255)));
            else send_cmd(OP_FREE, 8'($urandom_range(0, 255)));
        end
        repeat (6) send_cmd(OP_ALLOC, 8'($urandom_range(0, 255)));
        send_cmd(OP_CHECK, 8'hFF);
    endtask

    // ------------------------------------------------------------------
    // Result checker: every o_done cycle is one result transfer.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) begin
            n_results++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status=%0d grant=%0d bytes=%0d",
                             o_status, o_granted_index, o_outstanding_bytes);
            end else begin
                exp_head = expected_q.pop_front();
                if (exp_head.status == ST_NO_BLK)  n_no_blk++;
                if (exp_head.status == ST_REFUSED) n_refused++;
                if (exp_head.bytes == BYTES_SAT)   n_sat++;
                if (o_status !== exp_head.status || o_granted_index !== exp_head.granted ||
                    o_outstanding_bytes !== exp_head.bytes) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: exp status=%0d grant=%0d bytes=%0d,",
                                 n_results, exp_head.status, exp_head.granted,
                                 exp_head.bytes,
                                 " got status=%0d grant=%0d bytes=%0d",
                                 o_status, o_granted_index, o_outstanding_bytes);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        start           = 1'b0;
        i_op            = OP_CHECK;
        i_block_index   = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = REG_BLOCK_BYTES;
        i_cfg_data      = '0;
        i_rst_n         = 1'b0;
        no_idle         = 1'b0;
        cfg_block_bytes = 4;
        cfg_initial     = 0;
        cfg_grow        = 0;
        list_head       = NO_LINK;
        carved_cnt      = 0;
        free_cnt        = 0;
        pool_started    = 1'b0;
        foreach (link_mem[k]) link_mem[k] = 0;
        foreach (op_count[k]) op_count[k] = 0;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_initial_carve();
        test_growth_edges();
        test_full_pool();
        test_capacity();
        test_single_grow();
        test_random_config();
        test_free_saturation();

        drain();
        repeat (10) @(posedge i_clk);

        $display("Covered %0d commands (%0d alloc, %0d free, %0d check, %0d release),",
                 n_sent, op_count[OP_ALLOC], op_count[OP_FREE], op_count[OP_CHECK],
                 op_count[OP_RELEASE],
                 " %0d register writes, %0d carves.", n_cfg, n_carves);
        $display("Checked %0d results: %0d no-block, %0d refused releases,",
                 n_results, n_no_blk, n_refused,
                 " %0d saturated byte counts, %0d mismatches, %0d missing.",
                 n_sat, mismatches, expected_q.size());
        if (mismatches == 0 && expected_q.size() == 0)
            $display("[fixed_block_pool_allocator_top] OK");
        else
            $display("[fixed_block_pool_allocator_top] ERROR");
        $finish;
    end

endmodule
